/* hdl/bdpc_pkg.sv */
// Shared types and constants for the button debounce and press classifier.
`default_nettype none
package bdpc_pkg;

	localparam int TIME_BITS = 32;
	localparam int CFG_BITS  = 16;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_CHANGE = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [1:0] CLASS_NONE   = 2'd0;
	localparam logic [1:0] CLASS_SHORT  = 2'd1;
	localparam logic [1:0] CLASS_MEDIUM = 2'd2;
	localparam logic [1:0] CLASS_LONG   = 2'd3;

	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_MEDIUM   = 2'd1;
	localparam logic [1:0] REG_LONG     = 2'd2;
	localparam logic [1:0] REG_RELEASED = 2'd3;

	localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [CFG_BITS-1:0] MEDIUM_RESET   = 16'd500;
	localparam logic [CFG_BITS-1:0] LONG_RESET     = 16'd1000;
	localparam logic                RELEASED_RESET = 1'b1;

	typedef logic [TIME_BITS-1:0] time_val_t;

	typedef struct packed {
		logic [1:0] command;
		logic       pin_level;
	} item_t;

	typedef struct packed {
		logic [1:0] press_class;
		logic       event_pending;
	} result_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] debounce_ms;
		logic [CFG_BITS-1:0] medium_press_ms;
		logic [CFG_BITS-1:0] long_press_ms;
		logic                idle_level;
	} cfg_t;

endpackage
`default_nettype wire

/* hdl/bdpc_core.sv */
// Debounce and press classification state with its update logic.
`default_nettype none
module bdpc_core (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             step,
	input  bdpc_pkg::item_t   item,
	input  bdpc_pkg::cfg_t    cfg,
	output bdpc_pkg::result_t result
);
	import bdpc_pkg::*;

	time_val_t  time_now_q;
	time_val_t  last_change_q;
	time_val_t  press_start_q;
	logic       stable_level_q;
	logic [1:0] stored_class_q;
	logic       pending_q;

	time_val_t  since_change;
	time_val_t  held;
	logic       lockout;
	logic       accept_change;
	logic       is_release;
	logic [1:0] new_class;
	logic       query_hit;

	assign since_change  = time_now_q - last_change_q;
	assign held          = time_now_q - press_start_q;
	assign lockout       = since_change < TIME_BITS'(cfg.debounce_ms);
	assign accept_change = (item.command == CMD_CHANGE) && !lockout
		&& (item.pin_level != stable_level_q);
	assign is_release    = item.pin_level == cfg.idle_level;
	assign query_hit     = (item.command == CMD_QUERY) && pending_q;

	always_comb begin
		if (!is_release) begin
			new_class = CLASS_NONE;
		end else if (held >= TIME_BITS'(cfg.long_press_ms)) begin
			new_class = CLASS_LONG;
		end else if (held >= TIME_BITS'(cfg.medium_press_ms)) begin
			new_class = CLASS_MEDIUM;
		end else begin
			new_class = CLASS_SHORT;
		end
	end

	always_comb begin
		result.press_class   = query_hit ? stored_class_q : CLASS_NONE;
		result.event_pending = accept_change ? 1'b1 : (query_hit ? 1'b0 : pending_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_now_q     <= '0;
			last_change_q  <= '0;
			press_start_q  <= '0;
			stable_level_q <= RELEASED_RESET;
			stored_class_q <= CLASS_NONE;
			pending_q      <= 1'b0;
		end else if (step) begin
			if (item.command == CMD_TICK) begin
				time_now_q <= time_now_q + time_val_t'(1);
			end
			if (accept_change) begin
				stable_level_q <= item.pin_level;
				last_change_q  <= time_now_q;
				stored_class_q <= new_class;
				if (!is_release) begin
					press_start_q <= time_now_q;
				end
			end
			pending_q <= result.event_pending;
		end
	end

endmodule
`default_nettype wire

/* hdl/button_debounce_press_classifier.sv */
// Top level of the button debounce and press classifier.
//
//   Channel   Direction  Contents
//   s_axis    in         tuser[1:0] command, tdata[0] pin_level
//   m_axis    out        tdata[1:0] press_class, tdata[2] event_pending
//   cfg       in         cfg_index register number, cfg_data value (always ready)
//
// Every item gives one result, registered in the output register when the item leaves
// the input register; one item can be taken in every cycle while the output is not
// stalled. All classifier state updates happen in the cycle an item leaves the input
// register. A stalled output holds its result and the input register, and new items
// are refused only while both are full. Reset gives the listed register defaults and
// zero time.
`default_nettype none
module button_debounce_press_classifier (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [0] pin_level, [7:1] zero
	input  wire  [1:0] s_tuser,   // [1:0] command
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [1:0] press_class, [2] event_pending, [7:3] zero
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire  [1:0] cfg_index,
	input  wire [15:0] cfg_data
);
	import bdpc_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t result_q;
	logic    out_valid_q;
	result_t core_result;
	cfg_t    cfg_q;
	logic    advance;

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {5'b0, result_q.event_pending, result_q.press_class};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= DEBOUNCE_RESET;
			cfg_q.medium_press_ms <= MEDIUM_RESET;
			cfg_q.long_press_ms   <= LONG_RESET;
			cfg_q.idle_level      <= RELEASED_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ms     <= cfg_data;
				REG_MEDIUM:   cfg_q.medium_press_ms <= cfg_data;
				REG_LONG:     cfg_q.long_press_ms   <= cfg_data;
				REG_RELEASED: cfg_q.idle_level      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.command   <= s_tuser;
			item_s1.pin_level <= s_tdata[0];
		end
		if (advance) begin
			result_q <= core_result;
		end
	end

	bdpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (core_result)
	);

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the button debounce and press classifier with a built-in predictor.
module tb_top;
	import bdpc_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int TIMEOUT_NS = 4_000_000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic  [7:0] s_tdata;   // [0] pin_level, [7:1] zero
	logic  [1:0] s_tuser;   // [1:0] command
	logic        m_tvalid;
	logic        m_tready;
	logic  [7:0] m_tdata;   // [1:0] press_class, [2] event_pending, [7:3] zero
	logic        cfg_valid;
	logic        cfg_ready;
	logic  [1:0] cfg_index;
	logic [15:0] cfg_data;

	button_debounce_press_classifier u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	cfg_t       model_cfg;
	time_val_t  tick_count;
	time_val_t  last_change_at;
	time_val_t  press_began_at;
	logic       debounced_level;
	logic [1:0] held_class;
	logic       class_pending;
	result_t    expected_results[$];

	int   err_count = 0;
	int   items_sent = 0;
	int   results_checked = 0;
	int   settings_used = 0;
	int   class_seen[4] = '{0, 0, 0, 0};
	bit   tx_idle_on = 1'b0;
	bit   rx_idle_on = 1'b0;
	int   hold_req = 0;
	int   stall_left = 0;

	logic [15:0] stim_debounce = DEBOUNCE_RESET;
	logic [15:0] stim_medium = MEDIUM_RESET;
	logic [15:0] stim_long = LONG_RESET;
	logic        stim_released = RELEASED_RESET;

	task automatic reset_press_model();
		model_cfg = '{DEBOUNCE_RESET, MEDIUM_RESET, LONG_RESET, RELEASED_RESET};
		tick_count = '0;
		last_change_at = '0;
		press_began_at = '0;
		debounced_level = RELEASED_RESET;
		held_class = CLASS_NONE;
		class_pending = 1'b0;
	endtask

	task automatic classify_item(input item_t it, output result_t res);
		time_val_t since_change;
		time_val_t held_for;
		res.press_class = CLASS_NONE;
		case (it.command)
			CMD_TICK: begin
				tick_count = tick_count + time_val_t'(1);
			end
			CMD_CHANGE: begin
				since_change = tick_count - last_change_at;
				if (since_change >= time_val_t'(model_cfg.debounce_ms) &&
				    it.pin_level != debounced_level) begin
					debounced_level = it.pin_level;
					last_change_at = tick_count;
					if (debounced_level == model_cfg.idle_level) begin
						held_for = tick_count - press_began_at;
						if (held_for >= time_val_t'(model_cfg.long_press_ms))
							held_class = CLASS_LONG;
						else if (held_for >= time_val_t'(model_cfg.medium_press_ms))
							held_class = CLASS_MEDIUM;
						else
							held_class = CLASS_SHORT;
					end else begin
						press_began_at = tick_count;
						held_class = CLASS_NONE;
					end
					class_pending = 1'b1;
				end
			end
			CMD_QUERY: begin
				if (class_pending) begin
					class_pending = 1'b0;
					res.press_class = held_class;
				end
			end
			default: begin
			end
		endcase
		res.event_pending = class_pending;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	always @(posedge clk) begin : predict_results
		item_t   in_item;
		result_t in_res;
		if (arst_n && s_tvalid && s_tready) begin
			in_item.command = s_tuser;
			in_item.pin_level = s_tdata[0];
			classify_item(in_item, in_res);
			expected_results.push_back(in_res);
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE: model_cfg.debounce_ms = cfg_data;
				REG_MEDIUM:   model_cfg.medium_press_ms = cfg_data;
				REG_LONG:     model_cfg.long_press_ms = cfg_data;
				REG_RELEASED: model_cfg.idle_level = cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", int'(m_tdata), 0);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[1:0] != want.press_class)
					report_mismatch("press_class", int'(m_tdata[1:0]),
					                int'(want.press_class));
				if (m_tdata[2] != want.event_pending)
					report_mismatch("event_pending", int'(m_tdata[2]),
					                int'(want.event_pending));
				if (m_tdata[7:3] != 5'd0)
					report_mismatch("padding bits", int'(m_tdata[7:3]), 0);
				class_seen[m_tdata[1:0]]++;
			end
		end
	end

	// The receiver counts its own long hold-off and short random stalls.
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				m_tready <= 1'b0;
				hold_req--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, 3);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic [1:0] cmd, input logic lvl);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {7'd0, lvl};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(CMD_TICK, 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [15:0] deb, input logic [15:0] med,
	                          input logic [15:0] lng, input logic rel);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_MEDIUM, med);
		write_reg(REG_LONG, lng);
		write_reg(REG_RELEASED, {15'd0, rel});
		cfg_valid <= 1'b0;
		stim_debounce = deb;
		stim_medium = med;
		stim_long = lng;
		stim_released = rel;
		settings_used++;
	endtask

	task automatic test_startup_lockout();
		send_item(CMD_CHANGE, 1'b0);
		send_item(CMD_QUERY, 1'b1);
		send_item(CMD_UNUSED, 1'b1);
		send_item(CMD_TICK, 1'b0);
		send_item(CMD_CHANGE, 1'b0);
		wait_idle();
	endtask

	task automatic test_short_press();
		set_config(16'd2, 16'd3, 16'd6, 1'b1);
		send_item(CMD_TICK, 1'b1);
		send_item(CMD_CHANGE, 1'b0);
		send_item(CMD_QUERY, 1'b0);
		send_item(CMD_CHANGE, 1'b1);
		send_ticks(2);
		send_item(CMD_CHANGE, 1'b1);
		send_item(CMD_QUERY, 1'b0);
		send_item(CMD_QUERY, 1'b0);
		wait_idle();
	endtask

	task automatic test_config_extremes();
		set_config(16'hFFFF, 16'd0, 16'd0, 1'b1);
		send_item(CMD_CHANGE, 1'b0);
		wait_idle();
		// Flipping the released level leaves the debounced level untouched.
		set_config(16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
		send_item(CMD_CHANGE, 1'b0);
		send_item(CMD_QUERY, 1'b1);
		send_item(CMD_CHANGE, 1'b1);
		wait_idle();
		set_config(16'd0, 16'd0, 16'd0, 1'b0);
		send_item(CMD_CHANGE, 1'b0);
		send_item(CMD_QUERY, 1'b0);
		wait_idle();
		// Long threshold below medium: long wins once reached.
		set_config(16'd0, 16'd8, 16'd3, 1'b0);
		send_item(CMD_CHANGE, 1'b1);
		send_ticks(4);
		send_item(CMD_CHANGE, 1'b0);
		send_item(CMD_QUERY, 1'b0);
		wait_idle();
	endtask

	task automatic test_backpressure();
		set_config(16'd1, 16'd4, 16'd9, 1'b1);
		tx_idle_on = 1'b0;
		hold_req = 40;
		repeat (8) begin
			send_ticks(2);
			send_item(CMD_CHANGE, 1'b0);
			send_ticks($urandom_range(0, 10));
			send_item(CMD_CHANGE, 1'b1);
			send_item(CMD_QUERY, 1'b0);
		end
		wait_idle();
	endtask

	task automatic run_press_sessions(input int n_items, input bit idles);
		int   start;
		int   reach;
		logic press_lvl;
		start = items_sent;
		tx_idle_on = idles;
		rx_idle_on = idles;
		reach = (stim_long > stim_medium) ? int'(stim_long) : int'(stim_medium);
		press_lvl = ~stim_released;
		while (items_sent - start < n_items) begin
			if ($urandom_range(0, 9) < 7) begin
				send_ticks($urandom_range(0, int'(stim_debounce) + 2));
				send_item(CMD_CHANGE, press_lvl);
				if ($urandom_range(0, 2) == 0)
					send_item(CMD_CHANGE, ~press_lvl);
				if ($urandom_range(0, 1) == 0)
					send_item(CMD_QUERY, 1'($urandom_range(0, 1)));
				send_ticks($urandom_range(0, reach + 4));
				send_item(CMD_CHANGE, ~press_lvl);
				if ($urandom_range(0, 4) != 0)
					send_item(CMD_QUERY, 1'($urandom_range(0, 1)));
			end else begin
				repeat ($urandom_range(1, 6))
					send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
			end
		end
		wait_idle();
	endtask

	task automatic test_random_campaign();
		set_config(16'd3, 16'd5, 16'd12, 1'b1);
		run_press_sessions(130, 1'b1);
		set_config(16'd0, 16'd0, 16'd0, 1'b0);
		run_press_sessions(100, 1'b1);
		set_config(16'd1, 16'd10, 16'd4, 1'b1);
		run_press_sessions(120, 1'b1);
		set_config(16'($urandom_range(0, 5)), 16'($urandom_range(0, 15)),
		           16'($urandom_range(0, 25)), 1'($urandom_range(0, 1)));
		run_press_sessions(130, 1'b1);
		set_config(16'($urandom_range(0, 5)), 16'($urandom_range(2, 10)),
		           16'($urandom_range(8, 20)), 1'($urandom_range(0, 1)));
		run_press_sessions(130, 1'b0);
	endtask

	task automatic timeout_guard();
		#(TIMEOUT_NS);
		$display("tb_top failed");
		$finish;
	endtask

	initial begin
		timeout_guard();
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		s_tuser = CMD_TICK;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_data = 16'd0;
		reset_press_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_startup_lockout();
		test_short_press();
		test_config_extremes();
		test_backpressure();
		test_random_campaign();

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Run covered %0d input items and %0d results over %0d register settings.",
		         items_sent, results_checked, settings_used);
		$display("Queries returned short %0d, medium %0d, long %0d classified presses.",
		         class_seen[CLASS_SHORT], class_seen[CLASS_MEDIUM], class_seen[CLASS_LONG]);
		if (err_count == 0 && expected_results.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

/* sim.f */
hdl/bdpc_pkg.sv
hdl/bdpc_core.sv
hdl/button_debounce_press_classifier.sv
sim/tb_top.sv
